/* hdl/tdt_pkg.sv */
// Shared types and constants for the DIV/TIMA/TMA/TAC timer block.
// Beat payload structs, opcode and register codes, divider tap selection.
// No dependencies.
package tdt_pkg;

  typedef struct packed {
    logic [3:0] elapsed_cycles;
    logic [1:0] opcode;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
    logic [1:0] frame_clocks;
  } out_item_t;

  localparam logic [1:0] OP_TIME  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_TIMA = 2'd1;
  localparam logic [1:0] REG_TMA  = 2'd2;
  localparam logic [1:0] REG_TAC  = 2'd3;

  localparam logic [3:0] MAX_ELAPSED = 4'd8;
  localparam logic [7:0] TAC_UNUSED  = 8'hF8;

  localparam logic [3:0] FRAME_BIT_NORMAL = 4'd12;
  localparam logic [3:0] FRAME_BIT_DOUBLE = 4'd13;

  // Divider bit that clocks TIMA for each TAC clock choice.
  function automatic logic [3:0] tap_index(input logic [1:0] choice);
    logic [3:0] idx;
    unique case (choice)
      2'd0:    idx = 4'd9;
      2'd1:    idx = 4'd3;
      2'd2:    idx = 4'd5;
      default: idx = 4'd7;
    endcase
    return idx;
  endfunction

endpackage

/* hdl/div_tima_timer_registers.sv */
// Timer block top level: input register, step logic, result register.
// A beat is held in the input register once accepted; the input register feeds
// the step logic and the result register captures it when the beat advances.
// Throughput one beat per cycle; a stalled result holds the input register, and
// a new beat moves in on the same edge that the waiting result drains.
// Reset (synchronous, active high) clears all timer state, the speed select and
// both valid flags. Depends on tdt_pkg and tdt_core.
module div_tima_timer_registers import tdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic      dbl_speed;
  logic      stage_valid;
  in_item_t  stage_item;
  logic      advance;
  out_item_t step_result;

  // Step the held beat when the result register is free or draining.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  tdt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .dbl_speed (dbl_speed),
    .fire      (advance),
    .item      (stage_item),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dbl_speed   <= 1'b0;
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dbl_speed <= cfg_wr_data;
      end
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
    if (advance) begin
      out_item <= step_result;
    end
  end

endmodule

/* hdl/tdt_core.sv */
// Timer state and the single-pass step logic for one beat.
// Holds DIV, TIMA, TMA, TAC and the reload flags; depends on tdt_pkg.
module tdt_core import tdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      dbl_speed,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  logic [15:0] divider, divider_next;
  logic [7:0]  tima_count, tima_count_next;
  logic [7:0]  tma_modulo, tma_modulo_next;
  logic [1:0]  clock_choice, clock_choice_next;
  logic        timer_enable, timer_enable_next;
  logic        reload_pending, reload_pending_next;
  logic        just_reloaded, just_reloaded_next;

  logic [3:0]  el;
  logic        has_time;
  logic [3:0]  tap;
  logic [3:0]  fbit;
  logic [15:0] div_adv;
  logic [15:0] div1;
  logic [7:0]  tima1, tima2, tima_inc, tac_inc;
  logic        rp1, rp2, jr1;
  logic        irq_time, edge_time, frame_time;
  logic        edge_div, frame_div;
  logic        was_on, now_on;
  logic [3:0]  new_tap;
  logic        irq;
  logic [1:0]  frames;
  logic [7:0]  rd;

  assign el       = (item.elapsed_cycles > MAX_ELAPSED) ? MAX_ELAPSED : item.elapsed_cycles;
  assign has_time = (el != 4'd0);
  assign tap      = tap_index(clock_choice);
  assign fbit     = dbl_speed ? FRAME_BIT_DOUBLE : FRAME_BIT_NORMAL;
  assign div_adv  = divider + {12'd0, el};

  // Time update: pending reload first, then the divider advance.
  assign irq_time   = has_time && reload_pending;
  assign tima1      = irq_time ? tma_modulo : tima_count;
  assign rp1        = irq_time ? 1'b0 : reload_pending;
  assign jr1        = has_time ? irq_time : just_reloaded;
  assign edge_time  = has_time && timer_enable && divider[tap] && !div_adv[tap];
  assign frame_time = has_time && divider[fbit] && !div_adv[fbit];
  assign tima_inc   = tima1 + 8'd1;
  assign tima2      = edge_time ? tima_inc : tima1;
  assign rp2        = (edge_time && tima_inc == 8'd0) ? 1'b1 : rp1;
  assign div1       = has_time ? div_adv : divider;

  // Falling edges caused by a DIV write dropping the divider to zero.
  assign edge_div  = timer_enable && div1[tap];
  assign frame_div = div1[fbit];
  assign tac_inc   = tima2 + 8'd1;

  // TAC glitch: selected signal going from one to zero.
  assign new_tap = tap_index(item.write_data[1:0]);
  assign was_on  = timer_enable && div1[tap];
  assign now_on  = item.write_data[2] && div1[new_tap];

  always_comb begin
    divider_next        = div1;
    tima_count_next     = tima2;
    tma_modulo_next     = tma_modulo;
    clock_choice_next   = clock_choice;
    timer_enable_next   = timer_enable;
    reload_pending_next = rp2;
    just_reloaded_next  = jr1;
    irq                 = irq_time;
    frames              = {1'b0, frame_time};
    rd                  = 8'd0;
    case (item.opcode)
      OP_READ: begin
        unique case (item.reg_select)
          REG_DIV:  rd = div1[15:8];
          REG_TIMA: rd = tima2;
          REG_TMA:  rd = tma_modulo;
          REG_TAC:  rd = TAC_UNUSED | {5'd0, timer_enable, clock_choice};
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_select)
          REG_DIV: begin
            divider_next = 16'd0;
            if (edge_div) begin
              tima_count_next = tac_inc;
              if (tac_inc == 8'd0) begin
                reload_pending_next = 1'b1;
              end
            end
            if (frame_div) begin
              frames = frames + 2'd1;
            end
          end
          REG_TIMA: begin
            reload_pending_next = 1'b0;
            if (!jr1) begin
              tima_count_next = item.write_data;
            end
          end
          REG_TMA: begin
            tma_modulo_next = item.write_data;
            if (jr1) begin
              tima_count_next = item.write_data;
            end
          end
          REG_TAC: begin
            clock_choice_next = item.write_data[1:0];
            timer_enable_next = item.write_data[2];
            if (was_on && !now_on) begin
              if (tac_inc == 8'd0) begin
                // Wrap here reloads at once.
                tima_count_next     = tma_modulo;
                reload_pending_next = 1'b0;
                just_reloaded_next  = 1'b1;
                irq                 = 1'b1;
              end else begin
                tima_count_next = tac_inc;
              end
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  assign result.read_data    = rd;
  assign result.timer_irq    = irq;
  assign result.frame_clocks = frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider        <= 16'd0;
      tima_count     <= 8'd0;
      tma_modulo     <= 8'd0;
      clock_choice   <= 2'd0;
      timer_enable   <= 1'b0;
      reload_pending <= 1'b0;
      just_reloaded  <= 1'b0;
    end else if (fire) begin
      divider        <= divider_next;
      tima_count     <= tima_count_next;
      tma_modulo     <= tma_modulo_next;
      clock_choice   <= clock_choice_next;
      timer_enable   <= timer_enable_next;
      reload_pending <= reload_pending_next;
      just_reloaded  <= just_reloaded_next;
    end
  end

  a_irq_marks_reload: assert property (@(posedge clk) disable iff (rst)
    fire && result.timer_irq |=> just_reloaded)
    else $error("timer interrupt without reload mark");

  a_pending_reloads: assert property (@(posedge clk) disable iff (rst)
    fire && reload_pending && item.elapsed_cycles != 4'd0 |-> result.timer_irq)
    else $error("pending reload did not raise interrupt");

  a_div_write_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == OP_WRITE && item.reg_select == REG_DIV |=> divider == 16'd0)
    else $error("DIV write did not clear divider");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(divider) && $stable(tima_count) && $stable(reload_pending))
    else $error("timer state moved without a beat");

endmodule

/* tb/sv/div_tima_timer_registers_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the DIV/TIMA/TMA/TAC timer: watches both beat channels and
// the speed register, predicts each result and compares it field by field.
// Depends on tdt_pkg.
module div_tima_timer_registers_checker import tdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  output int        pending_count,
  output int        fail_count
);

  // Predicted timer state, mirrors the block's registers.
  logic        speed_dbl;
  logic [15:0] div_cnt;
  logic [7:0]  tima;
  logic [7:0]  tma;
  logic [1:0]  tac_sel;
  logic        tac_en;
  logic        reload_armed;
  logic        reloaded_now;

  // Per-beat accumulators.
  logic        irq_seen;
  logic [1:0]  frame_pulses;

  out_item_t   timer_results_q[$];
  int          errors = 0;

  function automatic logic [15:0] tap_mask(input logic [1:0] sel);
    logic [15:0] m;
    case (sel)
      2'd0:    m = 16'h0200;
      2'd1:    m = 16'h0008;
      2'd2:    m = 16'h0020;
      default: m = 16'h0080;
    endcase
    return m;
  endfunction

  function automatic void load_tima_from_tma();
    reload_armed = 1'b0;
    reloaded_now = 1'b1;
    tima         = tma;
    irq_seen     = 1'b1;
  endfunction

  // Move the divider to nxt and count the falling edges that causes.
  function automatic void step_divider(input logic [15:0] nxt);
    logic [15:0] tap;
    logic [15:0] fbit;
    tap  = tap_mask(tac_sel);
    fbit = speed_dbl ? 16'h2000 : 16'h1000;
    if (tac_en && (div_cnt & tap) != 16'd0 && (nxt & tap) == 16'd0) begin
      tima = tima + 8'd1;
      if (tima == 8'd0) reload_armed = 1'b1;
    end
    if ((div_cnt & fbit) != 16'd0 && (nxt & fbit) == 16'd0)
      frame_pulses = frame_pulses + 2'd1;
    div_cnt = nxt;
  endfunction

  function automatic out_item_t timer_step(input in_item_t it);
    logic [3:0] el;
    logic [7:0] rd;
    logic       was_on;
    logic       now_on;
    out_item_t  r;
    el = (it.elapsed_cycles > MAX_ELAPSED) ? MAX_ELAPSED : it.elapsed_cycles;
    rd = 8'd0;
    irq_seen = 1'b0;
    frame_pulses = 2'd0;
    // Time goes first: finish a pending reload, then advance the divider.
    if (el != 4'd0) begin
      reloaded_now = 1'b0;
      if (reload_armed) load_tima_from_tma();
      step_divider(div_cnt + {12'd0, el});
    end
    case (it.opcode)
      OP_READ: begin
        case (it.reg_select)
          REG_DIV:  rd = div_cnt[15:8];
          REG_TIMA: rd = tima;
          REG_TMA:  rd = tma;
          default:  rd = TAC_UNUSED | {5'd0, tac_en, tac_sel};
        endcase
      end
      OP_WRITE: begin
        case (it.reg_select)
          REG_DIV: step_divider(16'd0);
          REG_TIMA: begin
            reload_armed = 1'b0;
            if (!reloaded_now) tima = it.write_data;
          end
          REG_TMA: begin
            tma = it.write_data;
            if (reloaded_now) tima = it.write_data;
          end
          default: begin
            // A drop of the gated tap bit clocks TIMA once.
            was_on  = tac_en && (div_cnt & tap_mask(tac_sel)) != 16'd0;
            tac_sel = it.write_data[1:0];
            tac_en  = it.write_data[2];
            now_on  = tac_en && (div_cnt & tap_mask(tac_sel)) != 16'd0;
            if (was_on && !now_on) begin
              tima = tima + 8'd1;
              if (tima == 8'd0) load_tima_from_tma();
            end
          end
        endcase
      end
      default: ;
    endcase
    r.read_data    = rd;
    r.timer_irq    = irq_seen;
    r.frame_clocks = frame_pulses;
    return r;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      speed_dbl    = 1'b0;
      div_cnt      = 16'd0;
      tima         = 8'd0;
      tma          = 8'd0;
      tac_sel      = 2'd0;
      tac_en       = 1'b0;
      reload_armed = 1'b0;
      reloaded_now = 1'b0;
      timer_results_q.delete();
    end else begin
      if (cfg_wr_en) speed_dbl = cfg_wr_data;
      // Retire the output beat before queueing the new input beat.
      if (out_valid && out_ready) begin
        if (timer_results_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_item);
        end else begin
          want = timer_results_q.pop_front();
          compare_field("read_data", int'(want.read_data), int'(out_item.read_data));
          compare_field("timer_irq", int'(want.timer_irq), int'(out_item.timer_irq));
          compare_field("frame_clocks", int'(want.frame_clocks),
                        int'(out_item.frame_clocks));
        end
      end
      if (in_valid && in_ready) timer_results_q.push_back(timer_step(in_item));
    end
    pending_count <= timer_results_q.size();
    fail_count    <= errors;
  end

endmodule

/* tb/sv/div_tima_timer_registers_tb.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the DIV/TIMA/TMA/TAC timer block: directed beats,
// then biased random phases at both speed settings. Depends on tdt_pkg,
// div_tima_timer_registers and div_tima_timer_registers_checker.
module div_tima_timer_registers_tb;
  import tdt_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;

  int pending_count;
  int fail_count;
  int cycle_cnt = 0;
  int burst_left = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       choke_left = 0;

  always #2 clk = ~clk;

  div_tima_timer_registers u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  div_tima_timer_registers_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .pending_count (pending_count),
    .fail_count    (fail_count)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: switch between stall patterns every so often.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(3));
      rx_mode_left = $urandom_range(200, 20);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(1) == 1);
      RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
      default: begin
        if (choke_left == 0) begin
          out_ready  <= 1'b1;
          choke_left = $urandom_range(12, 1);
        end else begin
          out_ready  <= 1'b0;
          choke_left--;
        end
      end
    endcase
  end

  function automatic in_item_t beat_of(input logic [3:0] el, input logic [1:0] op,
                                       input logic [1:0] sel, input logic [7:0] data);
    in_item_t b;
    b.elapsed_cycles = el;
    b.opcode         = op;
    b.reg_select     = sel;
    b.write_data     = data;
    return b;
  endfunction

  // Mostly full-rate time with writes biased toward overflow and reload corners.
  function automatic in_item_t random_beat(input bit div_ok);
    in_item_t b;
    int p;
    p = $urandom_range(99);
    if (p < 10)      b.elapsed_cycles = 4'd0;
    else if (p < 20) b.elapsed_cycles = 4'($urandom_range(15, 9));
    else if (p < 30) b.elapsed_cycles = 4'($urandom_range(7, 1));
    else             b.elapsed_cycles = MAX_ELAPSED;
    b.reg_select = 2'($urandom_range(3));
    b.write_data = 8'($urandom_range(255));
    p = $urandom_range(99);
    if (p < 45)      b.opcode = OP_TIME;
    else if (p < 50) b.opcode = OP_SPARE;
    else if (p < 75) b.opcode = OP_READ;
    else begin
      b.opcode = OP_WRITE;
      p = $urandom_range(99);
      if (p < 30) begin
        b.reg_select = REG_TIMA;
        if ($urandom_range(9) < 7) b.write_data = 8'($urandom_range(255, 248));
      end else if (p < 55) begin
        b.reg_select = REG_TMA;
      end else if (p < 95 || !div_ok) begin
        b.reg_select = REG_TAC;
        if ($urandom_range(3) != 0) begin
          b.write_data[2] = 1'b1;
          if ($urandom_range(1) == 1) b.write_data[1:0] = 2'd1;
        end
      end else begin
        b.reg_select = REG_DIV;
      end
    end
    return b;
  endfunction

  // Present one beat; open a new burst, after a random gap, when the last ends.
  task automatic send_beat(input in_item_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_speed(input logic dbl);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dbl;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_speed(1'b0);

    // Overflow, reload window writes, cancel, TAC glitch wrap, DIV reset.
    send_beat(beat_of(4'd0,  OP_READ,  REG_TAC,  8'h00));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TAC,  8'h05));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TIMA, 8'hFF));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TMA,  8'hAB));
    send_beat(beat_of(4'd8,  OP_TIME,  REG_DIV,  8'h00));
    send_beat(beat_of(4'd8,  OP_TIME,  REG_DIV,  8'h00));
    send_beat(beat_of(4'd1,  OP_READ,  REG_TIMA, 8'h00));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TMA,  8'h3C));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TIMA, 8'h11));
    send_beat(beat_of(4'd0,  OP_READ,  REG_TIMA, 8'h00));
    send_beat(beat_of(4'd15, OP_SPARE, REG_TAC,  8'hFF));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TIMA, 8'hFF));
    send_beat(beat_of(4'd7,  OP_TIME,  REG_TIMA, 8'h00));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TIMA, 8'h80));
    send_beat(beat_of(4'd1,  OP_READ,  REG_TIMA, 8'h00));
    send_beat(beat_of(4'd8,  OP_TIME,  REG_TMA,  8'h00));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TIMA, 8'hFF));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TAC,  8'h00));
    send_beat(beat_of(4'd0,  OP_READ,  REG_TAC,  8'h00));
    send_beat(beat_of(4'd8,  OP_READ,  REG_DIV,  8'h00));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_DIV,  8'hFF));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TAC,  8'hFF));
    send_beat(beat_of(4'd0,  OP_READ,  REG_TAC,  8'h00));
    send_beat(beat_of(4'd9,  OP_READ,  REG_TMA,  8'h00));
    send_beat(beat_of(4'd0,  OP_WRITE, REG_TMA,  8'h00));

    // No DIV writes here so the divider runs past the normal frame bit edge.
    repeat (1250) send_beat(random_beat(1'b0));
    drain();
    write_speed(1'b1);
    repeat (100) send_beat(random_beat(1'b1));
    drain();
    write_speed(1'b0);
    repeat (50) send_beat(random_beat(1'b1));
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
